/* sv/rar_pkg.sv */
// ----------------------------------------------------------------------------
// rar_pkg
// Shared widths, operation and status codes, and the queue word for the
// rational arithmetic block.
// ----------------------------------------------------------------------------
package rar_pkg;

    localparam int VALUE_WIDTH = 16;
    localparam int PROD_W      = 2 * VALUE_WIDTH;
    localparam int SUM_W       = (PROD_W + 1 > 64) ? 64 : PROD_W + 1;
    localparam int NUM_W       = 33;
    localparam int DEN_W       = 31;
    localparam int CNT_W       = $clog2(SUM_W + 1);
    localparam int FIFO_DEPTH  = 2;

    typedef enum logic [1:0] {
        FUNC_ADD = 2'd0,
        FUNC_SUB = 2'd1,
        FUNC_MUL = 2'd2,
        FUNC_DIV = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_ZERO_DEN = 2'd2
    } status_t;

    typedef struct packed {
        status_t                  status;
        logic signed [SUM_W-1:0]  num;
        logic signed [SUM_W-1:0]  den;
    } rar_item_t;

endpackage

/* sv/rar_front.sv */
// ----------------------------------------------------------------------------
// rar_front
// Accepts a word, flags bad inputs, forms the cross products and the
// unreduced numerator and denominator, and pushes them to the queue.
// ----------------------------------------------------------------------------
module rar_front
    import rar_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    func,
    input  logic signed [VALUE_WIDTH-1:0] first_numerator,
    input  logic signed [VALUE_WIDTH-1:0] first_denominator,
    input  logic signed [VALUE_WIDTH-1:0] second_numerator,
    input  logic signed [VALUE_WIDTH-1:0] second_denominator,
    output logic                          push,
    output rar_item_t                     item,
    input  logic                          full
);

    logic                          a_valid_reg, a_valid_next;
    logic                          b_valid_reg, b_valid_next;
    func_t                         func_reg;
    logic signed [VALUE_WIDTH-1:0] n1_reg, d1_reg, n2_reg, d2_reg;
    func_t                         func_b_reg;
    status_t                       status_b_reg;
    logic signed [PROD_W-1:0]      pa_reg, pb_reg, pd_reg;
    logic signed [VALUE_WIDTH-1:0] ma_x, ma_y, mb_x, mb_y, md_x, md_y;
    status_t                       status_a;
    logic                          accept;

    assign busy   = a_valid_reg | b_valid_reg;
    assign accept = start & ~busy;
    assign push   = b_valid_reg & ~full;

    assign a_valid_next = accept;
    assign b_valid_next = a_valid_reg | (b_valid_reg & ~push);

    // classify
    always_comb
    begin
        if (d1_reg == '0 || d2_reg == '0)
            status_a = ST_ZERO_DEN;
        else if (func_reg == FUNC_DIV && n2_reg == '0)
            status_a = ST_DIV_ZERO;
        else
            status_a = ST_OK;
    end

    // operand selection for the three multipliers
    always_comb
    begin
        md_x = d1_reg;
        md_y = d2_reg;
        ma_x = n1_reg;
        ma_y = d2_reg;
        mb_x = n2_reg;
        mb_y = d1_reg;
        case (func_reg)
            FUNC_ADD, FUNC_SUB:
            begin
                mb_x = n2_reg;
            end
            FUNC_MUL:
            begin
                ma_y = n2_reg;
                mb_x = '0;
            end
            FUNC_DIV:
            begin
                md_y = n2_reg;
                mb_x = '0;
            end
            default:
            begin
                mb_x = '0;
            end
        endcase
    end

    always_comb
    begin
        item.status = status_b_reg;
        item.den    = SUM_W'(pd_reg);
        case (func_b_reg)
            FUNC_ADD: item.num = SUM_W'(pa_reg) + SUM_W'(pb_reg);
            FUNC_SUB: item.num = SUM_W'(pa_reg) - SUM_W'(pb_reg);
            default:  item.num = SUM_W'(pa_reg);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= func_t'(func);
            n1_reg   <= first_numerator;
            d1_reg   <= first_denominator;
            n2_reg   <= second_numerator;
            d2_reg   <= second_denominator;
        end
        if (a_valid_reg)
        begin
            func_b_reg   <= func_reg;
            status_b_reg <= status_a;
            pa_reg       <= ma_x * ma_y;
            pb_reg       <= mb_x * mb_y;
            pd_reg       <= md_x * md_y;
        end
    end

endmodule

/* sv/rar_fifo.sv */
// ----------------------------------------------------------------------------
// rar_fifo
// Short queue that decouples the front end from the reduction engine.
// ----------------------------------------------------------------------------
module rar_fifo
    import rar_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  rar_item_t wdata,
    output logic      full,
    input  logic      pop,
    output rar_item_t rdata,
    output logic      empty
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_FW = $clog2(FIFO_DEPTH + 1);

    rar_item_t         mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_FW-1:0] count_reg;

    assign full  = (count_reg == CNT_FW'(FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wdata;
    end

endmodule

/* sv/rar_reduce.sv */
// ----------------------------------------------------------------------------
// rar_reduce
// Back end: binary GCD, then two restoring dividers in step, then sign fixup.
// ----------------------------------------------------------------------------
module rar_reduce
    import rar_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    empty,
    input  rar_item_t               rdata,
    output logic                    pop,
    output logic                    done,
    output logic signed [NUM_W-1:0] result_numerator,
    output logic [DEN_W-1:0]        result_denominator,
    output logic [1:0]              status
);

    typedef enum logic [1:0] {S_IDLE, S_PREP, S_GCD, S_DIV} state_t;

    state_t             state_reg;
    logic [SUM_W-1:0]   a_reg, b_reg, g_reg, nq_reg, dq_reg, nr_reg, dr_reg;
    logic [CNT_W-1:0]   k_reg, cnt_reg;
    logic               neg_reg;
    logic               done_reg;
    logic [NUM_W-1:0]   num_out_reg;
    logic [DEN_W-1:0]   den_out_reg;
    status_t            status_reg;
    logic [SUM_W:0]     nrs, drs;
    logic [SUM_W-1:0]   nq_step, dq_step, nr_step, dr_step;

    function automatic logic [NUM_W-1:0] to_num(input logic [SUM_W-1:0] q);
        logic [SUM_W+NUM_W-1:0] e;
        e = {{NUM_W{1'b0}}, q};
        return e[NUM_W-1:0];
    endfunction

    function automatic logic [DEN_W-1:0] to_den(input logic [SUM_W-1:0] q);
        logic [SUM_W+DEN_W-1:0] e;
        e = {{DEN_W{1'b0}}, q};
        return e[DEN_W-1:0];
    endfunction

    assign pop = (state_reg == S_IDLE) && !empty;

    // one restoring step for each divider
    always_comb
    begin
        nrs = {nr_reg, nq_reg[SUM_W-1]};
        drs = {dr_reg, dq_reg[SUM_W-1]};
        if (nrs >= {1'b0, g_reg})
        begin
            nr_step = SUM_W'(nrs - {1'b0, g_reg});
            nq_step = {nq_reg[SUM_W-2:0], 1'b1};
        end
        else
        begin
            nr_step = nrs[SUM_W-1:0];
            nq_step = {nq_reg[SUM_W-2:0], 1'b0};
        end
        if (drs >= {1'b0, g_reg})
        begin
            dr_step = SUM_W'(drs - {1'b0, g_reg});
            dq_step = {dq_reg[SUM_W-2:0], 1'b1};
        end
        else
        begin
            dr_step = drs[SUM_W-1:0];
            dq_step = {dq_reg[SUM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            a_reg       <= '0;
            b_reg       <= '0;
            g_reg       <= '0;
            nq_reg      <= '0;
            dq_reg      <= '0;
            nr_reg      <= '0;
            dr_reg      <= '0;
            k_reg       <= '0;
            cnt_reg     <= '0;
            neg_reg     <= 1'b0;
            done_reg    <= 1'b0;
            num_out_reg <= '0;
            den_out_reg <= '0;
            status_reg  <= ST_OK;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (!empty)
                    begin
                        if (rdata.status != ST_OK || rdata.num == '0)
                        begin
                            num_out_reg <= '0;
                            den_out_reg <= DEN_W'(1);
                            status_reg  <= rdata.status;
                            done_reg    <= 1'b1;
                        end
                        else
                        begin
                            a_reg     <= rdata.num;
                            b_reg     <= rdata.den;
                            neg_reg   <= rdata.num[SUM_W-1] ^ rdata.den[SUM_W-1];
                            state_reg <= S_PREP;
                        end
                    end
                end
                S_PREP:
                begin
                    // take magnitudes
                    a_reg     <= a_reg[SUM_W-1] ? SUM_W'(-a_reg) : a_reg;
                    b_reg     <= b_reg[SUM_W-1] ? SUM_W'(-b_reg) : b_reg;
                    nq_reg    <= a_reg[SUM_W-1] ? SUM_W'(-a_reg) : a_reg;
                    dq_reg    <= b_reg[SUM_W-1] ? SUM_W'(-b_reg) : b_reg;
                    k_reg     <= '0;
                    state_reg <= S_GCD;
                end
                S_GCD:
                begin
                    if (a_reg == '0)
                    begin
                        g_reg     <= b_reg << k_reg;
                        nr_reg    <= '0;
                        dr_reg    <= '0;
                        cnt_reg   <= CNT_W'(SUM_W);
                        state_reg <= S_DIV;
                    end
                    else if (!a_reg[0] && !b_reg[0])
                    begin
                        a_reg <= a_reg >> 1;
                        b_reg <= b_reg >> 1;
                        k_reg <= k_reg + 1'b1;
                    end
                    else if (!a_reg[0])
                        a_reg <= a_reg >> 1;
                    else if (!b_reg[0])
                        b_reg <= b_reg >> 1;
                    else if (a_reg >= b_reg)
                        a_reg <= a_reg - b_reg;
                    else
                        b_reg <= b_reg - a_reg;
                end
                S_DIV:
                begin
                    nq_reg  <= nq_step;
                    dq_reg  <= dq_step;
                    nr_reg  <= nr_step;
                    dr_reg  <= dr_step;
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1))
                    begin
                        num_out_reg <= neg_reg ? NUM_W'(-to_num(nq_step)) : to_num(nq_step);
                        den_out_reg <= to_den(dq_step);
                        status_reg  <= ST_OK;
                        done_reg    <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done               = done_reg;
    assign result_numerator   = num_out_reg;
    assign result_denominator = den_out_reg;
    assign status             = status_reg;

    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> den_out_reg != '0)
        else $error("zero denominator delivered");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && status_reg != ST_OK |-> num_out_reg == '0 && den_out_reg == DEN_W'(1))
        else $error("error status without 0/1 result");

    a_gcd_b: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_GCD |-> b_reg != '0)
        else $error("gcd operand lost");

endmodule

/* sv/rational_arith_reduce.sv */
// ----------------------------------------------------------------------------
// rational_arith_reduce
// Adds, subtracts, multiplies or divides two signed fractions and returns the
// result reduced to lowest terms with a positive denominator.
// ----------------------------------------------------------------------------
// Path: the front registers the word, then the products, and pushes them to
//   the queue; the reduction engine then loads the word, takes magnitudes and
//   runs the binary GCD steps and SUM_W divide steps; error and zero results
//   are finished when they are loaded.
// Throughput: one word per reduction, set by the shared GCD and divider loop.
// Reset clears the front stages, the queue pointers and the engine state.
// The receiver cannot stall: done marks a result for exactly one cycle.
module rational_arith_reduce
    import rar_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    func,
    input  logic signed [VALUE_WIDTH-1:0] first_numerator,
    input  logic signed [VALUE_WIDTH-1:0] first_denominator,
    input  logic signed [VALUE_WIDTH-1:0] second_numerator,
    input  logic signed [VALUE_WIDTH-1:0] second_denominator,
    output logic                          done,
    output logic signed [NUM_W-1:0]       result_numerator,
    output logic [DEN_W-1:0]              result_denominator,
    output logic [1:0]                    status
);

    // front to queue
    logic      push;
    logic      full;
    rar_item_t push_item;
    // queue to engine
    logic      pop;
    logic      empty;
    rar_item_t pop_item;

    // Front end: register the word, classify and multiply.
    rar_front u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .func               (func),
        .first_numerator    (first_numerator),
        .first_denominator  (first_denominator),
        .second_numerator   (second_numerator),
        .second_denominator (second_denominator),
        .push               (push),
        .item               (push_item),
        .full               (full)
    );

    // Hold unreduced words while the engine is busy.
    rar_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (push_item),
        .full  (full),
        .pop   (pop),
        .rdata (pop_item),
        .empty (empty)
    );

    // Back end: reduce by the GCD and fix the sign.
    rar_reduce u_reduce (
        .clk                (clk),
        .rst_n              (rst_n),
        .empty              (empty),
        .rdata              (pop_item),
        .pop                (pop),
        .done               (done),
        .result_numerator   (result_numerator),
        .result_denominator (result_denominator),
        .status             (status)
    );

endmodule
